// ===== rtl/base32_digest_decoder_defines.svh =====
// Assertion macros for the base32 digest decoder checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BASE32_DIGEST_DECODER_DEFINES_SVH
`define BASE32_DIGEST_DECODER_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define B32DD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define B32DD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b32dd_pkg.sv =====
// Shared types and constants of the base32 digest decoder.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps

package b32dd_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 5;
    localparam int POS_W   = 3;

    localparam logic [BYTE_W-1:0]  UPPER_A      = 8'h41;
    localparam logic [BYTE_W-1:0]  UPPER_Z      = 8'h5A;
    localparam logic [BYTE_W-1:0]  LOWER_A      = 8'h61;
    localparam logic [BYTE_W-1:0]  LOWER_Z      = 8'h7A;
    localparam logic [BYTE_W-1:0]  CHAR_TWO     = 8'h32;
    localparam logic [BYTE_W-1:0]  CHAR_SEVEN   = 8'h37;
    localparam logic [DIGIT_W-1:0] NUMBER_BASE  = 5'h1A;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    typedef enum logic {
        PH_DIGIT,
        PH_FLUSH
    } t_phase;

endpackage

// ===== rtl/b32dd_if.sv =====
// Handshake interfaces for the character input and the byte output.
// Depends on b32dd_pkg for the field widths.
`timescale 1ns / 1ps

interface b32dd_char_if;
    logic                          valid;
    logic                          ready;
    logic [b32dd_pkg::BYTE_W-1:0]  character;
    logic                          end_of_text;

    modport source (output valid, output character, output end_of_text, input ready);
    modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface b32dd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [b32dd_pkg::BYTE_W-1:0]  digest_byte;
    logic                          final_byte;

    modport source (output valid, output digest_byte, output final_byte, input ready);
    modport sink   (input valid, input digest_byte, input final_byte, output ready);
endinterface

// ===== rtl/b32dd_digit.sv =====
// Maps one character to its base32 digit value and a valid flag.
// Depends on b32dd_pkg.
`timescale 1ns / 1ps

module b32dd_digit (
    input  logic [b32dd_pkg::BYTE_W-1:0] i_character,
    output b32dd_pkg::t_digit            o_digit
);

    logic                             is_upper;
    logic                             is_lower;
    logic                             is_number;
    logic [b32dd_pkg::BYTE_W-1:0]     upper_off;
    logic [b32dd_pkg::BYTE_W-1:0]     lower_off;
    logic [b32dd_pkg::BYTE_W-1:0]     number_off;

    assign is_upper  = (i_character >= b32dd_pkg::UPPER_A) && (i_character <= b32dd_pkg::UPPER_Z);
    assign is_lower  = (i_character >= b32dd_pkg::LOWER_A) && (i_character <= b32dd_pkg::LOWER_Z);
    assign is_number = (i_character >= b32dd_pkg::CHAR_TWO)
                    && (i_character <= b32dd_pkg::CHAR_SEVEN);

    assign upper_off  = i_character - b32dd_pkg::UPPER_A;
    assign lower_off  = i_character - b32dd_pkg::LOWER_A;
    assign number_off = i_character - b32dd_pkg::CHAR_TWO;

    always_comb begin
        o_digit.valid = is_upper || is_lower || is_number;
        priority if (is_upper) begin
            o_digit.value = upper_off[b32dd_pkg::DIGIT_W-1:0];
        end else if (is_lower) begin
            o_digit.value = lower_off[b32dd_pkg::DIGIT_W-1:0];
        end else if (is_number) begin
            o_digit.value = number_off[b32dd_pkg::DIGIT_W-1:0] + b32dd_pkg::NUMBER_BASE;
        end else begin
            o_digit.value = '0;
        end
    end

endmodule

// ===== rtl/base32_digest_decoder.sv =====
// An accepted character is held in the input register; the byte it completes is then written
// to the output register, which holds it until the byte is taken.
// Throughput: one character per cycle while the output is taken; an end mark holds the
// input until the remaining digest bytes have been flushed through the single output register.
// Reset: synchronous, active low; clears both registers' valid bits and the packing state.
// Depends on b32dd_pkg, b32dd_if and b32dd_digit.
`timescale 1ns / 1ps

module base32_digest_decoder #(
    parameter int DIGEST_BYTES = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    b32dd_char_if.sink          i_char,
    b32dd_byte_if.source        o_byte
);

    localparam int CW = $clog2(DIGEST_BYTES + 1);
    localparam logic [CW-1:0] N_BYTES = CW'(DIGEST_BYTES);
    localparam int BW = b32dd_pkg::BYTE_W;
    localparam int DW = b32dd_pkg::DIGIT_W;
    localparam int PW = b32dd_pkg::POS_W;

    logic                     r_in_valid;
    logic [BW-1:0]            r_char;
    logic                     r_eot;
    logic                     r_out_valid;
    logic [BW-1:0]            r_out_byte;
    logic                     r_out_final;
    logic [BW-1:0]            r_partial;
    logic [PW-1:0]            r_pos;
    logic [CW-1:0]            r_emitted;
    b32dd_pkg::t_phase        r_phase;

    logic [BW-1:0]            n_partial;
    logic [PW-1:0]            n_pos;
    logic [CW-1:0]            n_emitted;
    b32dd_pkg::t_phase        n_phase;

    b32dd_pkg::t_digit        digit;
    logic                     out_free;
    logic                     room;
    logic [CW-1:0]            emitted_inc;
    logic                     inc_final;
    logic [PW-1:0]            npos;
    logic [BW+DW-1:0]         left_sh;
    logic [BW-1:0]            right_sh;
    logic                     emit;
    logic [BW-1:0]            emit_byte;
    logic                     go;
    logic                     consume;

    b32dd_digit u_digit (
        .i_character (r_char),
        .o_digit     (digit)
    );

    assign out_free    = !r_out_valid || o_byte.ready;
    assign room        = r_emitted < N_BYTES;
    assign emitted_inc = r_emitted + CW'(1);
    assign inc_final   = emitted_inc == N_BYTES;
    assign npos        = r_pos + PW'(5);
    assign left_sh     = {{BW{1'b0}}, digit.value} << (4'd8 - {1'b0, npos});
    assign right_sh    = {{(BW-DW){1'b0}}, digit.value} >> npos;

    always_comb begin
        n_partial = r_partial;
        n_pos     = r_pos;
        n_emitted = r_emitted;
        n_phase   = r_phase;
        emit      = 1'b0;
        emit_byte = '0;
        go        = 1'b0;
        consume   = 1'b0;
        unique case (r_phase)
            b32dd_pkg::PH_DIGIT: begin
                if (digit.valid && room) begin
                    if (r_pos <= PW'(3)) begin
                        if (npos == '0) begin
                            emit      = 1'b1;
                            emit_byte = r_partial | {{(BW-DW){1'b0}}, digit.value};
                            n_partial = '0;
                            n_emitted = emitted_inc;
                        end else begin
                            n_partial = r_partial | left_sh[BW-1:0];
                        end
                        n_pos = npos;
                    end else begin
                        emit      = 1'b1;
                        emit_byte = r_partial | right_sh;
                        n_emitted = emitted_inc;
                        if (!inc_final) begin
                            n_partial = left_sh[BW-1:0];
                            n_pos     = npos;
                        end else begin
                            n_partial = '0;
                            n_pos     = '0;
                        end
                    end
                end
                go = r_in_valid && (!emit || out_free);
                if (r_eot) begin
                    if (n_emitted < N_BYTES) begin
                        n_phase = b32dd_pkg::PH_FLUSH;
                    end else begin
                        consume   = go;
                        n_partial = '0;
                        n_pos     = '0;
                        n_emitted = '0;
                    end
                end else begin
                    consume = go;
                end
            end
            b32dd_pkg::PH_FLUSH: begin
                emit      = 1'b1;
                emit_byte = r_partial;
                go        = out_free;
                n_partial = '0;
                n_emitted = emitted_inc;
                if (inc_final) begin
                    consume   = go;
                    n_pos     = '0;
                    n_emitted = '0;
                    n_phase   = b32dd_pkg::PH_DIGIT;
                end
            end
            default: begin
                n_phase = b32dd_pkg::PH_DIGIT;
            end
        endcase
    end

    assign i_char.ready       = !r_in_valid || consume;
    assign o_byte.valid       = r_out_valid;
    assign o_byte.digest_byte = r_out_byte;
    assign o_byte.final_byte  = r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= b32dd_pkg::PH_DIGIT;
            r_partial <= '0;
            r_pos     <= '0;
            r_emitted <= '0;
        end else if (go) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_pos     <= n_pos;
            r_emitted <= n_emitted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.character;
            r_eot  <= i_char.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out_byte  <= emit_byte;
            r_out_final <= inc_final;
        end
    end

endmodule

// ===== rtl/b32dd_checker.sv =====
// Port-level checks of the base32 digest decoder, bound to its top level.
// Depends on base32_digest_decoder_defines.svh and b32dd_pkg.
`timescale 1ns / 1ps
`include "base32_digest_decoder_defines.svh"

module b32dd_checker #(
    parameter int DIGEST_BYTES = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [b32dd_pkg::BYTE_W-1:0]  i_digest_byte,
    input  logic                          i_final_byte
);

    localparam int CW = $clog2(DIGEST_BYTES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(DIGEST_BYTES - 1);

    logic          r_cnt_valid;
    logic [CW-1:0] r_cnt;
    logic          out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    // Counts bytes taken since the last final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_cnt_valid <= 1'b1;
        end else if (out_acc) begin
            r_cnt <= i_final_byte ? '0 : r_cnt + CW'(1);
        end
    end

    `B32DD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_digest_byte) && $stable(i_final_byte), "Output item changed while stalled.")
    `B32DD_ASSERT_NOW(a_final_position, out_acc && r_cnt_valid, i_final_byte == (r_cnt == LAST_IDX), "Final mark is not on the last digest byte.")
    `B32DD_ASSERT_NOW(a_count_bound, i_out_valid && r_cnt_valid, r_cnt <= LAST_IDX, "More digest bytes than the digest holds.")

endmodule

bind base32_digest_decoder b32dd_checker #(
    .DIGEST_BYTES (DIGEST_BYTES)
) u_b32dd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_byte.valid),
    .i_out_ready   (o_byte.ready),
    .i_digest_byte (o_byte.digest_byte),
    .i_final_byte  (o_byte.final_byte)
);

// ===== verif/base32_digest_decoder_checker.sv =====
// Scoreboard for the base32 digest decoder: predicts every digest byte from the
// accepted characters and compares it with the bytes taken at the output.
// Depends on b32dd_pkg and the channel interfaces in b32dd_if.
`timescale 1ns / 1ps

module base32_digest_decoder_checker #(
    parameter int DIGEST_BYTES = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    b32dd_char_if   i_char_mon,
    b32dd_byte_if   i_byte_mon,
    output int      o_error_count,
    output int      o_bytes_due,
    output int      o_bytes_checked
);

    localparam int BW = b32dd_pkg::BYTE_W;
    localparam int PW = b32dd_pkg::POS_W;

    typedef struct {
        logic [BW-1:0] value;
        logic          last;
    } t_digest_entry;

    t_digest_entry      bytes_due_q[$];
    logic [BW-1:0]      partial = '0;
    logic [PW-1:0]      fill = '0;
    logic [4:0]         emitted = '0;
    int                 errors = 0;
    int                 checked = 0;

    function automatic int digit_of_char(logic [BW-1:0] ch);
        if (ch >= b32dd_pkg::UPPER_A && ch <= b32dd_pkg::UPPER_Z) begin
            return int'(ch - b32dd_pkg::UPPER_A);
        end
        if (ch >= b32dd_pkg::LOWER_A && ch <= b32dd_pkg::LOWER_Z) begin
            return int'(ch - b32dd_pkg::LOWER_A);
        end
        if (ch >= b32dd_pkg::CHAR_TWO && ch <= b32dd_pkg::CHAR_SEVEN) begin
            return int'(ch - b32dd_pkg::CHAR_TWO) + int'(b32dd_pkg::NUMBER_BASE);
        end
        return -1;
    endfunction

    function automatic void queue_byte(logic [BW-1:0] value);
        t_digest_entry entry;
        emitted     = emitted + 5'd1;
        entry.value = value;
        entry.last  = (emitted == DIGEST_BYTES);
        bytes_due_q.push_back(entry);
    endfunction

    function automatic void decode_char(logic [BW-1:0] ch, logic eot);
        int             digit;
        logic [BW-1:0]  dv;
        logic [PW-1:0]  npos;
        digit = digit_of_char(ch);
        if (digit >= 0 && emitted < DIGEST_BYTES) begin
            dv   = digit[BW-1:0];
            npos = fill + 3'd5;
            if (fill <= 3) begin
                if (npos == 0) begin
                    queue_byte(partial | dv);
                    partial = '0;
                end else begin
                    partial = partial | (dv << (BW - npos));
                end
                fill = npos;
            end else begin
                queue_byte(partial | (dv >> npos));
                if (emitted < DIGEST_BYTES) begin
                    partial = dv << (BW - npos);
                    fill    = npos;
                end else begin
                    partial = '0;
                    fill    = '0;
                end
            end
        end
        if (eot) begin
            if (fill != 0 && emitted < DIGEST_BYTES) begin
                queue_byte(partial);
            end
            while (emitted < DIGEST_BYTES) begin
                queue_byte('0);
            end
            partial = '0;
            fill    = '0;
            emitted = '0;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_digest_entry want;
        if (!i_rst_n) begin
            partial = '0;
            fill    = '0;
            emitted = '0;
            bytes_due_q.delete();
        end else begin
            if (i_char_mon.valid && i_char_mon.ready) begin
                decode_char(i_char_mon.character, i_char_mon.end_of_text);
            end
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                checked++;
                if (bytes_due_q.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t ns: unexpected item, byte %02h final %0b", $time,
                                 i_byte_mon.digest_byte, i_byte_mon.final_byte);
                    end
                    errors++;
                end else begin
                    want = bytes_due_q.pop_front();
                    if (i_byte_mon.digest_byte !== want.value
                            || i_byte_mon.final_byte !== want.last) begin
                        if (errors < 10) begin
                            $display("%0t ns: expected byte %02h final %0b, got byte %02h final %0b",
                                     $time, want.value, want.last,
                                     i_byte_mon.digest_byte, i_byte_mon.final_byte);
                        end
                        errors++;
                    end
                end
            end
        end
        o_error_count   <= errors;
        o_bytes_due     <= bytes_due_q.size();
        o_bytes_checked <= checked;
    end

endmodule

// ===== verif/base32_digest_decoder_tb.sv =====
// Top of the base32 digest decoder testbench: clock, reset, character stimulus,
// output stalls and the verdict. Depends on b32dd_pkg, b32dd_if, the decoder
// and base32_digest_decoder_checker.
`timescale 1ns / 1ps

module base32_digest_decoder_tb;

    localparam int DIGEST_BYTES = 20;
    localparam int PHASE_ITEMS  = 52;
    localparam int BW           = b32dd_pkg::BYTE_W;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   chars_sent     = 0;
    int   end_marks_sent = 0;
    int   error_count;
    int   bytes_due;
    int   bytes_checked;

    b32dd_char_if char_ch ();
    b32dd_byte_if byte_ch ();

    base32_digest_decoder #(
        .DIGEST_BYTES (DIGEST_BYTES)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_ch),
        .o_byte  (byte_ch)
    );

    base32_digest_decoder_checker #(
        .DIGEST_BYTES (DIGEST_BYTES)
    ) checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_char_mon      (char_ch),
        .i_byte_mon      (byte_ch),
        .o_error_count   (error_count),
        .o_bytes_due     (bytes_due),
        .o_bytes_checked (bytes_checked)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        byte_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic bit is_base32(logic [BW-1:0] ch);
        return (ch >= b32dd_pkg::UPPER_A && ch <= b32dd_pkg::UPPER_Z)
            || (ch >= b32dd_pkg::LOWER_A && ch <= b32dd_pkg::LOWER_Z)
            || (ch >= b32dd_pkg::CHAR_TWO && ch <= b32dd_pkg::CHAR_SEVEN);
    endfunction

    function automatic logic [BW-1:0] base32_char();
        case ($urandom_range(2))
            0:       return b32dd_pkg::UPPER_A + BW'($urandom_range(25));
            1:       return b32dd_pkg::LOWER_A + BW'($urandom_range(25));
            default: return b32dd_pkg::CHAR_TWO + BW'($urandom_range(5));
        endcase
    endfunction

    function automatic logic [BW-1:0] noise_char();
        logic [BW-1:0] ch;
        ch = BW'($urandom_range(255));
        while (is_base32(ch)) begin
            ch = BW'($urandom_range(255));
        end
        return ch;
    endfunction

    task automatic send_char(input logic [BW-1:0] ch, input logic eot);
        if ($urandom_range(99) < send_idle_pct) begin
            char_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        char_ch.valid       <= 1'b1;
        char_ch.character   <= ch;
        char_ch.end_of_text <= eot;
        @(posedge clk);
        while (!char_ch.ready) @(posedge clk);
        chars_sent++;
        if (eot) end_marks_sent++;
    endtask

    task automatic send_random_text();
        int n_digits;
        int noise_pct;
        bit end_on_digit;
        if ($urandom_range(99) < 20) n_digits = $urandom_range(30, 40);
        else n_digits = $urandom_range(0, 12);
        noise_pct    = $urandom_range(1) ? 0 : 15;
        end_on_digit = $urandom_range(1);
        for (int i = 0; i < n_digits; i++) begin
            if ($urandom_range(99) < noise_pct) send_char(noise_char(), 1'b0);
            send_char(base32_char(), end_on_digit && (i == n_digits - 1));
        end
        if (!end_on_digit || n_digits == 0) send_char(noise_char(), 1'b1);
    endtask

    task automatic send_noise_burst();
        int n_chars;
        n_chars = $urandom_range(1, 8);
        for (int i = 0; i < n_chars; i++) begin
            send_char(BW'($urandom_range(255)), ($urandom_range(7) == 0));
        end
    endtask

    initial begin
        int phase_start;
        rst_n               <= 1'b0;
        char_ch.valid       <= 1'b0;
        char_ch.character   <= '0;
        char_ch.end_of_text <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty text gives a digest of all-zero bytes.
        send_char(8'h00, 1'b1);
        send_char(b32dd_pkg::UPPER_A, 1'b0);
        send_char(b32dd_pkg::UPPER_Z, 1'b0);
        send_char(b32dd_pkg::LOWER_A, 1'b0);
        send_char(b32dd_pkg::LOWER_Z, 1'b0);
        send_char(b32dd_pkg::CHAR_TWO, 1'b0);
        send_char(b32dd_pkg::CHAR_SEVEN, 1'b0);
        send_char(b32dd_pkg::UPPER_A - 8'd1, 1'b0);
        send_char(b32dd_pkg::UPPER_Z + 8'd1, 1'b0);
        send_char(b32dd_pkg::LOWER_A - 8'd1, 1'b0);
        send_char(b32dd_pkg::LOWER_Z + 8'd1, 1'b0);
        send_char(b32dd_pkg::CHAR_TWO - 8'd1, 1'b0);
        send_char(b32dd_pkg::CHAR_SEVEN + 8'd1, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(b32dd_pkg::CHAR_SEVEN, 1'b1);
        send_char(b32dd_pkg::UPPER_A + 8'd16, 1'b1);
        send_char(b32dd_pkg::UPPER_A + 8'd12, 1'b0);
        send_char(b32dd_pkg::LOWER_A + 8'd13, 1'b0);
        send_char(8'h2E, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 75) send_random_text();
                else send_noise_burst();
            end
            // Close any text left open so the next phase starts clean.
            send_char(noise_char(), 1'b1);
        end

        char_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0) @(posedge clk);
        repeat (2 * DIGEST_BYTES + 10) @(posedge clk);

        $display("Sent %0d characters holding %0d end marks under four idle and stall mixes.",
                 chars_sent, end_marks_sent);
        $display("Checked %0d digest bytes, %0d of them in error.", bytes_checked, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d digest bytes still due.", bytes_due);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/b32dd_pkg.sv
rtl/b32dd_if.sv
rtl/b32dd_digit.sv
rtl/base32_digest_decoder.sv
rtl/b32dd_checker.sv
verif/base32_digest_decoder_checker.sv
verif/base32_digest_decoder_tb.sv
